// ===== src/lpab_pkg.sv =====
// Shared types, constants and helpers for the length-prefixed to Annex B converter.
`default_nettype none

package lpab_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_CODEC_MODE       = 2'd0;
  localparam logic [1:0] REG_LENGTH_BYTES     = 2'd1;
  localparam logic [1:0] REG_EMULATION_ENABLE = 2'd2;

  // Codec modes; any mode with the upper bit set behaves as AVC.
  localparam logic [1:0] MODE_HEVC = 2'd0;
  localparam logic [1:0] MODE_VVC  = 2'd1;
  localparam logic [1:0] MODE_AVC  = 2'd2;

  localparam logic [2:0] LEN_BYTES_MIN = 3'd1;
  localparam logic [2:0] LEN_BYTES_MAX = 3'd4;

  // NAL type ranges that call for the long start code (low bound, high bound exclusive).
  localparam logic [5:0] HEVC_LONG_LO = 6'd32;
  localparam logic [5:0] HEVC_LONG_HI = 6'd41;
  localparam logic [4:0] VVC_LONG_LO  = 5'd12;
  localparam logic [4:0] VVC_LONG_HI  = 5'd20;

  localparam logic [7:0] EPB_BYTE      = 8'h03;
  localparam logic [7:0] START_ZERO    = 8'h00;
  localparam logic [7:0] START_ONE     = 8'h01;

  // Progress through the first payload bytes of a unit.
  localparam logic [1:0] PI_NONE    = 2'd0;
  localparam logic [1:0] PI_HELD    = 2'd1;
  localparam logic [1:0] PI_DECIDED = 2'd2;

  // Slots of one command, emitted from the lowest set bit upward.
  localparam int          NUM_SLOTS  = 8;
  localparam int          SLOT_W     = $clog2(NUM_SLOTS);
  localparam logic [SLOT_W-1:0] SLOT_LONG_ZERO = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_ZERO_A    = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_ZERO_B    = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_ONE       = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_EPB0      = 3'd4;
  localparam logic [SLOT_W-1:0] SLOT_P0        = 3'd5;
  localparam logic [SLOT_W-1:0] SLOT_EPB1      = 3'd6;
  localparam logic [SLOT_W-1:0] SLOT_P1        = 3'd7;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [1:0] codec_mode;
    logic [2:0] length_bytes;
    logic       emulation_enable;
  } cfg_t;

  typedef struct packed {
    logic [NUM_SLOTS-1:0] mask;
    logic [7:0]           p0;
    logic [7:0]           p1;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  function automatic logic [7:0] slot_byte(logic [SLOT_W-1:0] slot, logic [7:0] p0,
                                           logic [7:0] p1);
    logic [7:0] b;
    b = START_ZERO;
    unique case (slot) inside
      SLOT_LONG_ZERO, SLOT_ZERO_A, SLOT_ZERO_B: b = START_ZERO;
      SLOT_ONE:                                 b = START_ONE;
      SLOT_EPB0, SLOT_EPB1:                     b = EPB_BYTE;
      SLOT_P0:                                  b = p0;
      SLOT_P1:                                  b = p1;
      default:                                  b = START_ZERO;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== src/lpab_front.sv =====
// Front end: parses length prefixes, decides start codes and builds output commands.
`default_nettype none

module lpab_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           accept,
  input  wire logic [7:0]     in_byte,
  input  wire lpab_pkg::cfg_t cfg,
  output lpab_pkg::cmd_t      cmd,
  output logic                push
);

  logic        in_length_phase, in_length_phase_next;
  logic [2:0]  prefix_count, prefix_count_next;
  logic [31:0] bytes_left, bytes_left_next;
  logic [1:0]  payload_index, payload_index_next;
  logic [7:0]  held_byte, held_byte_next;
  logic [1:0]  zero_run, zero_run_next;
  logic        first_unit, first_unit_next;

  logic [2:0]  len_eff;
  logic [2:0]  pc_inc;
  logic        is_avc;
  logic        is_vvc;
  logic        last;
  logic        start, long_code;
  logic        has0, ins0, has1, ins1;
  logic [7:0]  p0, p1;
  logic [1:0]  zr_mid;

  function automatic logic want_long(logic first, logic avc, logic vvc, logic [7:0] b0,
                                     logic [7:0] b1, logic has_second);
    logic [5:0] t0;
    logic [4:0] t1;
    logic       r;
    t0 = b0[6:1];
    t1 = b1[7:3];
    if (first || avc) begin
      r = 1'b1;
    end else if (vvc) begin
      r = has_second && (t1 >= lpab_pkg::VVC_LONG_LO) && (t1 < lpab_pkg::VVC_LONG_HI);
    end else begin
      r = (t0 >= lpab_pkg::HEVC_LONG_LO) && (t0 < lpab_pkg::HEVC_LONG_HI);
    end
    return r;
  endfunction

  function automatic logic needs_epb(logic en, logic [1:0] zr, logic [7:0] b);
    return en && (zr >= 2'd2) && (b <= lpab_pkg::EPB_BYTE);
  endfunction

  function automatic logic [1:0] zr_after(logic [1:0] zr, logic ins, logic [7:0] b);
    logic [1:0] z;
    z = ins ? 2'd0 : zr;
    if (b == 8'd0) begin
      return (z >= 2'd2) ? 2'd2 : z + 2'd1;
    end
    return 2'd0;
  endfunction

  always_comb begin
    case (cfg.length_bytes) inside
      3'd0:         len_eff = lpab_pkg::LEN_BYTES_MIN;
      [3'd1:3'd4]:  len_eff = cfg.length_bytes;
      default:      len_eff = lpab_pkg::LEN_BYTES_MAX;
    endcase
  end

  assign is_avc = cfg.codec_mode[1];
  assign is_vvc = (cfg.codec_mode == lpab_pkg::MODE_VVC);
  assign pc_inc = prefix_count + 3'd1;
  assign last   = (bytes_left == 32'd1);

  always_comb begin
    in_length_phase_next = in_length_phase;
    prefix_count_next    = prefix_count;
    bytes_left_next      = bytes_left;
    payload_index_next   = payload_index;
    held_byte_next       = held_byte;
    zero_run_next        = zero_run;
    first_unit_next      = first_unit;
    start     = 1'b0;
    long_code = 1'b0;
    has0      = 1'b0;
    ins0      = 1'b0;
    has1      = 1'b0;
    ins1      = 1'b0;
    p0        = in_byte;
    p1        = in_byte;
    zr_mid    = 2'd0;

    if (accept) begin
      if (in_length_phase) begin
        bytes_left_next = (prefix_count == 3'd0) ? {24'd0, in_byte}
                                                 : {bytes_left[23:0], in_byte};
        if (pc_inc >= len_eff) begin
          prefix_count_next  = 3'd0;
          payload_index_next = lpab_pkg::PI_NONE;
          if (bytes_left_next == 32'd0) begin
            start     = 1'b1;
            long_code = first_unit || is_avc;
          end else begin
            in_length_phase_next = 1'b0;
            if (is_avc) begin
              start              = 1'b1;
              long_code          = 1'b1;
              payload_index_next = lpab_pkg::PI_DECIDED;
            end
          end
        end else begin
          prefix_count_next = pc_inc;
        end
        if (start) begin
          zero_run_next = 2'd0;
        end
      end else begin
        bytes_left_next = bytes_left - 32'd1;
        if (payload_index >= lpab_pkg::PI_DECIDED) begin
          has0          = 1'b1;
          ins0          = needs_epb(cfg.emulation_enable, zero_run, in_byte);
          zero_run_next = zr_after(zero_run, ins0, in_byte);
        end else if (payload_index == lpab_pkg::PI_HELD) begin
          // The held first byte and this byte follow the start code, which clears the run.
          start              = 1'b1;
          long_code          = want_long(first_unit, is_avc, is_vvc, held_byte, in_byte, 1'b1);
          has0               = 1'b1;
          p0                 = held_byte;
          ins0               = 1'b0;
          zr_mid             = zr_after(2'd0, 1'b0, held_byte);
          has1               = 1'b1;
          ins1               = needs_epb(cfg.emulation_enable, zr_mid, in_byte);
          zero_run_next      = zr_after(zr_mid, ins1, in_byte);
          payload_index_next = lpab_pkg::PI_DECIDED;
        end else if (is_vvc && !last) begin
          held_byte_next     = in_byte;
          payload_index_next = lpab_pkg::PI_HELD;
        end else begin
          start              = 1'b1;
          long_code          = want_long(first_unit, is_avc, is_vvc, in_byte, 8'd0, 1'b0);
          has0               = 1'b1;
          zero_run_next      = zr_after(2'd0, 1'b0, in_byte);
          payload_index_next = lpab_pkg::PI_DECIDED;
        end
        if (last) begin
          in_length_phase_next = 1'b1;
          prefix_count_next    = 3'd0;
          payload_index_next   = lpab_pkg::PI_NONE;
        end
      end
      if (start) begin
        first_unit_next = 1'b0;
      end
    end
  end

  always_comb begin
    cmd.mask                           = '0;
    cmd.mask[lpab_pkg::SLOT_LONG_ZERO] = start && long_code;
    cmd.mask[lpab_pkg::SLOT_ZERO_A]    = start;
    cmd.mask[lpab_pkg::SLOT_ZERO_B]    = start;
    cmd.mask[lpab_pkg::SLOT_ONE]       = start;
    cmd.mask[lpab_pkg::SLOT_EPB0]      = ins0;
    cmd.mask[lpab_pkg::SLOT_P0]        = has0;
    cmd.mask[lpab_pkg::SLOT_EPB1]      = ins1;
    cmd.mask[lpab_pkg::SLOT_P1]        = has1;
    cmd.p0                             = p0;
    cmd.p1                             = p1;
  end

  assign push = accept && (cmd.mask != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_length_phase <= 1'b1;
      prefix_count    <= 3'd0;
      bytes_left      <= 32'd0;
      payload_index   <= lpab_pkg::PI_NONE;
      held_byte       <= 8'd0;
      zero_run        <= 2'd0;
      first_unit      <= 1'b1;
    end else begin
      in_length_phase <= in_length_phase_next;
      prefix_count    <= prefix_count_next;
      bytes_left      <= bytes_left_next;
      payload_index   <= payload_index_next;
      held_byte       <= held_byte_next;
      zero_run        <= zero_run_next;
      first_unit      <= first_unit_next;
    end
  end

  // While payload is being consumed there is always at least one byte still owed.
  a_payload_nonzero: assert property (@(posedge clk) disable iff (rst)
    !in_length_phase |-> bytes_left != 32'd0)
    else $error("payload phase with no bytes left");

  // The held state only arises in VVC-style units and never persists into the length phase.
  a_held_in_payload: assert property (@(posedge clk) disable iff (rst)
    payload_index == lpab_pkg::PI_HELD |-> !in_length_phase)
    else $error("held byte outstanding during length phase");

endmodule

`default_nettype wire

// ===== src/lpab_fifo.sv =====
// Short command queue between the front end and the byte emitter.
`default_nettype none

module lpab_fifo (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  input  wire lpab_pkg::cmd_t         push_cmd,
  input  wire logic                   pop,
  output lpab_pkg::cmd_t              head,
  output lpab_pkg::fifo_status_t      status
);

  lpab_pkg::cmd_t                 entries [lpab_pkg::FIFO_DEPTH];
  logic [lpab_pkg::FIFO_AW-1:0]   wr_ptr;
  logic [lpab_pkg::FIFO_AW-1:0]   rd_ptr;
  logic [lpab_pkg::FIFO_AW:0]     count;

  assign status.full  = (count == (lpab_pkg::FIFO_AW + 1)'(lpab_pkg::FIFO_DEPTH));
  assign status.empty = (count == '0);
  assign head         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !status.full)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !status.empty)
    else $error("pop from an empty queue");

endmodule

`default_nettype wire

// ===== src/lpab_back.sv =====
// Back end: expands queued commands into bytes in an output register, one per unstalled cycle.
`default_nettype none

module lpab_back (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire lpab_pkg::cmd_t         head,
  input  wire lpab_pkg::fifo_status_t status,
  output logic                        pop,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [7:0]                  out_byte,
  output logic                        run_last
);

  logic [lpab_pkg::NUM_SLOTS-1:0] cur_mask;
  logic [7:0]                     cur_p0, cur_p1;
  logic                           have;
  logic [lpab_pkg::NUM_SLOTS-1:0] src_mask, rem_mask;
  logic [7:0]                     src_p0, src_p1;
  logic [lpab_pkg::SLOT_W-1:0]    slot;
  logic                           out_free;
  logic                           emit;

  assign have     = (cur_mask != '0);
  assign src_mask = have ? cur_mask : head.mask;
  assign src_p0   = have ? cur_p0 : head.p0;
  assign src_p1   = have ? cur_p1 : head.p1;
  // Clearing the lowest set bit leaves the slots still to go.
  assign rem_mask = src_mask & (src_mask - 1'b1);

  always_comb begin
    slot = '0;
    for (int i = lpab_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
      if (src_mask[i]) begin
        slot = lpab_pkg::SLOT_W'(i);
      end
    end
  end

  assign out_free = !out_valid || !out_stall;
  assign emit     = out_free && (have || !status.empty);
  assign pop      = emit && !have;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cur_mask  <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        cur_mask  <= rem_mask;
      end else if (out_free) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= lpab_pkg::slot_byte(slot, src_p0, src_p1);
      run_last <= (rem_mask == '0);
    end
    if (pop) begin
      cur_p0 <= head.p0;
      cur_p1 <= head.p1;
    end
  end

  // Every queued command carries at least one byte.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.mask != '0)
    else $error("empty command in queue");

  // A pending remainder of a command is drained before another command is taken.
  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    have |-> !pop)
    else $error("command taken while one is still in progress");

endmodule

`default_nettype wire

// ===== src/length_prefixed_to_annex_b_nal_unit.sv =====
// Length-prefixed NAL unit stream to Annex B byte stream converter, top level.
//
// Input channel (in_valid, in_stall, in_byte) takes one byte of the length-prefixed stream
// per request. Output channel (out_valid, out_stall, out_byte, run_last) gives one Annex B
// byte per request; run_last marks the last output byte caused by an input byte. Input bytes
// that cause no output (most prefix bytes, a held first VVC byte) give nothing on the output.
// The configuration registers (codec mode, prefix length, emulation prevention enable) are
// written through write_enable, write_index and write_data; the user must write them only
// while the block is idle, which the block itself does not enforce.
//
// Throughput: one input byte per cycle while the output keeps up; the output carries one byte
// per cycle while the receiver does not stall, and an input byte expands to up to 6 output
// bytes (a four-byte start code and two payload bytes). A four-entry command queue absorbs
// start-code bursts. An accepted byte's command enters the queue; the back end then moves its
// first byte into the output register. Reset clears the parsing state, marks the next unit as
// the first one and loads the register defaults. When the receiver stalls, the output register
// holds; the queue fills and then in_stall is raised until room frees up.
`default_nettype none

module length_prefixed_to_annex_b_nal_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            run_last,
  input  wire logic       write_enable,
  input  wire logic [1:0] write_index,
  input  wire logic [2:0] write_data
);

  lpab_pkg::cfg_t         cfg;
  lpab_pkg::cmd_t         front_cmd;
  lpab_pkg::cmd_t         head;
  lpab_pkg::fifo_status_t status;
  logic                   accept;
  logic                   push;
  logic                   pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.codec_mode       <= lpab_pkg::MODE_HEVC;
      cfg.length_bytes     <= lpab_pkg::LEN_BYTES_MAX;
      cfg.emulation_enable <= 1'b1;
    end else if (write_enable) begin
      case (write_index)
        lpab_pkg::REG_CODEC_MODE:       cfg.codec_mode       <= write_data[1:0];
        lpab_pkg::REG_LENGTH_BYTES:     cfg.length_bytes     <= write_data;
        lpab_pkg::REG_EMULATION_ENABLE: cfg.emulation_enable <= write_data[0];
        default: ;
      endcase
    end
  end

  assign in_stall = status.full;
  assign accept   = in_valid && !in_stall;

  lpab_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (in_byte),
    .cfg     (cfg),
    .cmd     (front_cmd),
    .push    (push)
  );

  lpab_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (front_cmd),
    .pop      (pop),
    .head     (head),
    .status   (status)
  );

  lpab_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .status    (status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .run_last  (run_last)
  );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the length-prefixed to Annex B NAL unit converter.
module tb;

  localparam int RANDOM_ITEMS   = 280;
  localparam int STALL_PCT      = 13;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int SCRIPT_LEN     = 37;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } annexb_byte_t;

  // One directed step: a register write, or an input byte with an optional typed-in answer.
  typedef struct packed {
    logic        is_reg;
    logic [1:0]  idx;
    logic [2:0]  data;
    logic [7:0]  b;
    logic        typed;
    logic [2:0]  n;
    logic [31:0] exp;
  } script_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       run_last;
  logic       write_enable = 1'b0;
  logic [1:0] write_index = lpab_pkg::REG_CODEC_MODE;
  logic [2:0] write_data = 3'd0;

  length_prefixed_to_annex_b_nal_unit uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_byte(in_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte(out_byte),
    .run_last(run_last),
    .write_enable(write_enable),
    .write_index(write_index),
    .write_data(write_data)
  );

  // Converter state as seen by the predictor.
  lpab_pkg::cfg_t cfg = '{codec_mode: lpab_pkg::MODE_HEVC,
                          length_bytes: lpab_pkg::LEN_BYTES_MAX,
                          emulation_enable: 1'b1};
  logic        in_len_phase = 1'b1;
  logic [2:0]  pfx_cnt = 3'd0;
  logic [31:0] remaining = 32'd0;
  logic [1:0]  stage = lpab_pkg::PI_NONE;
  logic [7:0]  held = 8'h00;
  logic [1:0]  zeros = 2'd0;
  logic        first_nal = 1'b1;

  annexb_byte_t annexb_due[$];
  logic [7:0]   unit_bytes[$];
  int           sent = 0;
  int           mismatches = 0;
  int           idle_cycles = 0;
  bit           calm = 1'b0;

  script_row_t script [0:SCRIPT_LEN-1] = '{
    '{1'b0, lpab_pkg::REG_CODEC_MODE, 3'd0, 8'h00, 1'b1, 3'd0, 32'h0},
    '{1'b0, lpab_pkg::REG_CODEC_MODE, 3'd0, 8'h00, 1'b1, 3'd0, 32'h0},
    '{1'b0, lpab_pkg::REG_CODEC_MODE, 3'd0, 8'h00, 1'b1, 3'd0, 32'h0},
    '{1'b0, lpab_pkg::REG_CODEC_MODE, 3'd0, 8'h00, 1'b1, 3'd4, 32'h00000001},
    '{1'b1, lpab_pkg::REG_LENGTH_BYTES, lpab_pkg::LEN_BYTES_MIN, 8'h00, 1'b0, 3'd0, 32'h0},
    '{1'b0, lpab_pkg::REG_CODEC_MODE, 3'd0, 8'h00, 1'b1, 3'd3, 32'h000001},
    '{1'b0, lpab_pkg::REG_CODEC_MODE, 3'd0, 8'h04, 1'b1, 3'd0, 32'h0},
    '{1'b0, lpab_pkg::REG_CODEC_MODE, 3'd0, 8'h40, 1'b0, 3'd0, 32'h0},
    '{1'b0, lpab_pkg::REG_CODEC_MODE, 3'd0, 8'h00, 1'b0, 3'd0, 32'h0},
    '{1'b0, lpab_pkg::REG_CODEC_MODE, 3'd0, 8'h00, 1'b0, 3'd0, 32'h0},
    '{1'b0, lpab_pkg::REG_CODEC_MODE, 3'd0, 8'h03, 1'b0, 3'd0, 32'h0},
    '{1'b1, lpab_pkg::REG_CODEC_MODE, {1'b0, lpab_pkg::MODE_VVC}, 8'h00, 1'b0, 3'd0, 32'h0},
    '{1'b0, lpab_pkg::REG_CODEC_MODE, 3'd0, 8'h01, 1'b1, 3'd0, 32'h0},
    '{1'b0, lpab_pkg::REG_CODEC_MODE, 3'd0, 8'hFF, 1'b0, 3'd0, 32'h0},
    '{1'b0, lpab_pkg::REG_CODEC_MODE, 3'd0, 8'h02, 1'b1, 3'd0, 32'h0},
    '{1'b0, lpab_pkg::REG_CODEC_MODE, 3'd0, 8'h00, 1'b1, 3'd0, 32'h0},
    '{1'b0, lpab_pkg::REG_CODEC_MODE, 3'd0, 8'h60, 1'b0, 3'd0, 32'h0},
    // Mode three has the upper bit set, so it must act as AVC.
    '{1'b1, lpab_pkg::REG_CODEC_MODE,
      {1'b0, lpab_pkg::MODE_AVC | lpab_pkg::MODE_VVC}, 8'h00, 1'b0, 3'd0, 32'h0},
    '{1'b0, lpab_pkg::REG_CODEC_MODE, 3'd0, 8'h01, 1'b1, 3'd4, 32'h00000001},
    '{1'b0, lpab_pkg::REG_CODEC_MODE, 3'd0, 8'hFF, 1'b0, 3'd0, 32'h0},
    '{1'b1, lpab_pkg::REG_EMULATION_ENABLE, 3'd0, 8'h00, 1'b0, 3'd0, 32'h0},
    '{1'b1, lpab_pkg::REG_LENGTH_BYTES, 3'd7, 8'h00, 1'b0, 3'd0, 32'h0},
    '{1'b0, lpab_pkg::REG_CODEC_MODE, 3'd0, 8'h00, 1'b1, 3'd0, 32'h0},
    '{1'b0, lpab_pkg::REG_CODEC_MODE, 3'd0, 8'h00, 1'b1, 3'd0, 32'h0},
    '{1'b0, lpab_pkg::REG_CODEC_MODE, 3'd0, 8'h00, 1'b1, 3'd0, 32'h0},
    '{1'b0, lpab_pkg::REG_CODEC_MODE, 3'd0, 8'h03, 1'b1, 3'd4, 32'h00000001},
    '{1'b0, lpab_pkg::REG_CODEC_MODE, 3'd0, 8'h00, 1'b0, 3'd0, 32'h0},
    '{1'b0, lpab_pkg::REG_CODEC_MODE, 3'd0, 8'h00, 1'b0, 3'd0, 32'h0},
    '{1'b0, lpab_pkg::REG_CODEC_MODE, 3'd0, 8'h03, 1'b0, 3'd0, 32'h0},
    '{1'b1, lpab_pkg::REG_CODEC_MODE, {1'b0, lpab_pkg::MODE_VVC}, 8'h00, 1'b0, 3'd0, 32'h0},
    '{1'b1, lpab_pkg::REG_LENGTH_BYTES, 3'd0, 8'h00, 1'b0, 3'd0, 32'h0},
    '{1'b0, lpab_pkg::REG_CODEC_MODE, 3'd0, 8'h02, 1'b1, 3'd0, 32'h0},
    '{1'b0, lpab_pkg::REG_CODEC_MODE, 3'd0, 8'h40, 1'b1, 3'd0, 32'h0},
    // The held byte is decided under HEVC rules after this write.
    '{1'b1, lpab_pkg::REG_CODEC_MODE, {1'b0, lpab_pkg::MODE_HEVC}, 8'h00, 1'b0, 3'd0, 32'h0},
    '{1'b0, lpab_pkg::REG_CODEC_MODE, 3'd0, 8'h00, 1'b0, 3'd0, 32'h0},
    '{1'b1, lpab_pkg::REG_EMULATION_ENABLE, 3'd1, 8'h00, 1'b0, 3'd0, 32'h0},
    '{1'b0, lpab_pkg::REG_CODEC_MODE, 3'd0, 8'h00, 1'b1, 3'd3, 32'h000001}
  };

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int prefix_width();
    if (cfg.length_bytes == 3'd0) return 1;
    if (cfg.length_bytes > lpab_pkg::LEN_BYTES_MAX) return 4;
    return int'(cfg.length_bytes);
  endfunction

  function automatic logic [7:0] pick_payload(int pos);
    logic [7:0] b;
    int         r;
    b = 8'($urandom);
    r = $urandom_range(99);
    if (pos == 0 && r < 25) begin
      b[6:1] = 6'($urandom_range(42, 30));
    end else if (pos == 1 && r < 25) begin
      b[7:3] = 5'($urandom_range(21, 10));
    end else if (r < 55) begin
      b = 8'h00;
    end else if (r < 67) begin
      b = 8'($urandom_range(3, 1));
    end
    return b;
  endfunction

  task automatic add_unit_byte(input logic [7:0] v);
    unit_bytes.insert(unit_bytes.size(), v);
  endtask

  task automatic emit_payload(input logic [7:0] b);
    if (cfg.emulation_enable && zeros == 2'd2 && b <= lpab_pkg::EPB_BYTE) begin
      add_unit_byte(lpab_pkg::EPB_BYTE);
      zeros = 2'd0;
    end
    if (b == 8'h00) begin
      if (zeros != 2'd2) zeros = zeros + 2'd1;
    end else begin
      zeros = 2'd0;
    end
    add_unit_byte(b);
  endtask

  task automatic emit_start(input logic long_code);
    if (long_code) add_unit_byte(lpab_pkg::START_ZERO);
    add_unit_byte(lpab_pkg::START_ZERO);
    add_unit_byte(lpab_pkg::START_ZERO);
    add_unit_byte(lpab_pkg::START_ONE);
    first_nal = 1'b0;
    zeros = 2'd0;
  endtask

  function automatic logic wants_long(logic [7:0] b0, logic [7:0] b1, logic has_b1);
    logic [5:0] hevc_type;
    logic [4:0] vvc_type;
    hevc_type = b0[6:1];
    vvc_type = b1[7:3];
    if (first_nal || cfg.codec_mode[1]) return 1'b1;
    if (cfg.codec_mode == lpab_pkg::MODE_VVC)
      return has_b1 && vvc_type >= lpab_pkg::VVC_LONG_LO && vvc_type < lpab_pkg::VVC_LONG_HI;
    return hevc_type >= lpab_pkg::HEVC_LONG_LO && hevc_type < lpab_pkg::HEVC_LONG_HI;
  endfunction

  // Works out the Annex B bytes that one input byte produces, into unit_bytes.
  task automatic convert_byte(input logic [7:0] b);
    logic fin;
    unit_bytes.delete();
    if (in_len_phase) begin
      remaining = (pfx_cnt == 3'd0) ? {24'd0, b} : {remaining[23:0], b};
      pfx_cnt = pfx_cnt + 3'd1;
      if (int'(pfx_cnt) >= prefix_width()) begin
        pfx_cnt = 3'd0;
        stage = lpab_pkg::PI_NONE;
        if (remaining == 32'd0) begin
          emit_start(first_nal || cfg.codec_mode[1]);
        end else begin
          in_len_phase = 1'b0;
          if (cfg.codec_mode[1]) begin
            emit_start(1'b1);
            stage = lpab_pkg::PI_DECIDED;
          end
        end
      end
    end else begin
      remaining = remaining - 32'd1;
      fin = (remaining == 32'd0);
      if (stage == lpab_pkg::PI_DECIDED) begin
        emit_payload(b);
      end else if (stage == lpab_pkg::PI_HELD) begin
        emit_start(wants_long(held, b, 1'b1));
        emit_payload(held);
        emit_payload(b);
        stage = lpab_pkg::PI_DECIDED;
      end else if (cfg.codec_mode == lpab_pkg::MODE_VVC && !fin) begin
        // VVC carries its type in the second byte, so the first one waits.
        held = b;
        stage = lpab_pkg::PI_HELD;
      end else begin
        emit_start(wants_long(b, 8'h00, 1'b0));
        emit_payload(b);
        stage = lpab_pkg::PI_DECIDED;
      end
      if (fin) begin
        in_len_phase = 1'b1;
        pfx_cnt = 3'd0;
        stage = lpab_pkg::PI_NONE;
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic typed, input logic [2:0] n,
                           input logic [31:0] exp);
    int           gap;
    int           cnt;
    annexb_byte_t item;
    gap = 0;
    calm = (sent >= 150 && sent < 230);
    while (!calm && $urandom_range(99) < STALL_PCT && gap < 30) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (in_stall);
    sent++;
    convert_byte(b);
    if (typed) begin
      cnt = int'(n);
      unit_bytes.delete();
      for (int k = 0; k < cnt; k++) add_unit_byte(exp[8*(cnt-1-k) +: 8]);
    end
    for (int k = 0; k < unit_bytes.size(); k++) begin
      item.value = unit_bytes[k];
      item.last = (k == unit_bytes.size() - 1);
      annexb_due.insert(annexb_due.size(), item);
    end
  endtask

  // Lets every pending request drain before the registers change.
  task automatic settle();
    in_valid <= 1'b0;
    while (annexb_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [2:0] data);
    write_enable <= 1'b1;
    write_index <= idx;
    write_data <= data;
    @(posedge clk);
    case (idx)
      lpab_pkg::REG_CODEC_MODE:       cfg.codec_mode = data[1:0];
      lpab_pkg::REG_LENGTH_BYTES:     cfg.length_bytes = data;
      lpab_pkg::REG_EMULATION_ENABLE: cfg.emulation_enable = data[0];
      default: ;
    endcase
    write_enable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic note_mismatch(input string want_txt);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: got out_byte %h run_last %b, expected %s", $time, out_byte, run_last,
               want_txt);
  endtask

  always @(posedge clk) begin
    annexb_byte_t want;
    if (!rst && out_valid && !out_stall) begin
      if (annexb_due.size() == 0) begin
        note_mismatch("no byte");
      end else begin
        want = annexb_due.pop_front();
        if (out_byte !== want.value || run_last !== want.last)
          note_mismatch($sformatf("out_byte %h run_last %b", want.value, want.last));
      end
    end
    out_stall <= !calm && ($urandom_range(99) < STALL_PCT);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("length_prefixed_to_annex_b_nal_unit regression: fail");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int  stop_at;
    int  units;
    int  len;
    int  cut;
    int  nb;
    int  r;
    bit  first_phase;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].is_reg) begin
        settle();
        write_reg(script[i].idx, script[i].data);
      end else begin
        send_byte(script[i].b, script[i].typed, script[i].n, script[i].exp);
      end
    end

    stop_at = sent + RANDOM_ITEMS;
    first_phase = 1'b1;
    while (sent < stop_at) begin
      settle();
      if (first_phase || $urandom_range(1))
        write_reg(lpab_pkg::REG_CODEC_MODE, 3'($urandom_range(3)));
      if (first_phase || $urandom_range(1))
        write_reg(lpab_pkg::REG_LENGTH_BYTES,
                  ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4, 1)));
      if (first_phase || $urandom_range(1))
        write_reg(lpab_pkg::REG_EMULATION_ENABLE, 3'($urandom_range(1)));
      first_phase = 1'b0;
      // A unit cut short in the previous phase is finished under the new settings.
      while (!in_len_phase) send_byte(pick_payload(2), 1'b0, 3'd0, 32'h0);
      units = $urandom_range(5, 1);
      for (int u = 0; u < units; u++) begin
        r = $urandom_range(99);
        if (r < 15) len = 0;
        else if (r < 30) len = 1;
        else if (r < 80) len = $urandom_range(8, 2);
        else len = $urandom_range(40, 9);
        cut = len;
        if (u == units - 1 && len >= 2 && $urandom_range(4) == 0) cut = $urandom_range(len - 1, 1);
        nb = prefix_width();
        for (int k = nb - 1; k >= 0; k--) send_byte(8'(len >> (8 * k)), 1'b0, 3'd0, 32'h0);
        for (int k = 0; k < cut; k++) send_byte(pick_payload(k), 1'b0, 3'd0, 32'h0);
      end
    end

    settle();
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("length_prefixed_to_annex_b_nal_unit regression: pass");
    end else begin
      $display("length_prefixed_to_annex_b_nal_unit regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/lpab_pkg.sv
src/lpab_front.sv
src/lpab_fifo.sv
src/lpab_back.sv
src/length_prefixed_to_annex_b_nal_unit.sv
tb/tb.sv
